### hdl/aoks_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aoks_pkg
// Shared types, constants and functions for the AES OFB keystream cipher.
// ----------------------------------------------------------------------------
package aoks_pkg;

    // key size codes
    localparam logic [1:0] KEY_128 = 2'd0;
    localparam logic [1:0] KEY_192 = 2'd1;
    localparam logic [1:0] KEY_256 = 2'd2;

    // bytes in one cipher block
    localparam int BLOCK_BYTES = 16;

    // built-in key, byte k in bits 8k+7:8k
    localparam logic [255:0] FIXED_KEY = {
        8'h00, 8'h00, 8'h00, 8'h52, 8'h00, 8'h00, 8'h00, 8'h33,
        8'h00, 8'h00, 8'h00, 8'h0F, 8'h00, 8'h00, 8'h00, 8'h1B,
        8'h00, 8'h00, 8'h00, 8'hB4, 8'h00, 8'h00, 8'h00, 8'h06,
        8'h00, 8'h00, 8'h00, 8'h08, 8'h00, 8'h00, 8'h00, 8'h13};

    // cipher engine states
    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_KEYX,
        ENG_ROUND
    } eng_state_t;

    // request from stream control to the engine
    typedef struct packed {
        logic         go;
        logic [127:0] src;
    } eng_req_t;

    // engine status back to stream control
    typedef struct packed {
        logic busy;
        logic done;
    } eng_stat_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        unique case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // subbytes + shiftrows on a 16-byte state, byte c*4+r
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                o[(c*4+r)*8 +: 8] = sbox(s[(((c + r) & 3)*4 + r)*8 +: 8]);
        return o;
    endfunction

    function automatic logic [127:0] mix_all(input logic [127:0] s);
        logic [127:0] o;
        logic [7:0] a0, a1, a2, a3, t;
        for (int c = 0; c < 4; c++) begin
            a0 = s[(c*4)*8 +: 8];
            a1 = s[(c*4+1)*8 +: 8];
            a2 = s[(c*4+2)*8 +: 8];
            a3 = s[(c*4+3)*8 +: 8];
            t  = a0 ^ a1 ^ a2 ^ a3;
            o[(c*4)*8 +: 8]   = a0 ^ t ^ xtime(a0 ^ a1);
            o[(c*4+1)*8 +: 8] = a1 ^ t ^ xtime(a1 ^ a2);
            o[(c*4+2)*8 +: 8] = a2 ^ t ^ xtime(a2 ^ a3);
            o[(c*4+3)*8 +: 8] = a3 ^ t ^ xtime(a3 ^ a0);
        end
        return o;
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] i);
        logic [7:0] r;
        unique case (i)
            4'd1: r = 8'h01; 4'd2: r = 8'h02; 4'd3: r = 8'h04; 4'd4: r = 8'h08;
            4'd5: r = 8'h10; 4'd6: r = 8'h20; 4'd7: r = 8'h40; 4'd8: r = 8'h80;
            4'd9: r = 8'h1b; 4'd10: r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

### hdl/aes_ofb_keystream_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_ofb_keystream_cipher
// AES output-feedback byte stream cipher with a built-in key.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one byte per transfer; tuser is start_req, tlast the
//   packet's last flag. A start byte loads the IV (vector repeated four
//   times) and encrypts it before that byte is answered.
//   m_axis returns data XOR keystream; tlast copies the input's last flag.
//   cfg_valid/cfg_ready writes key_size (0:128, 1:192, 2:256, 3 as 256);
//   cfg_ready is low while the engine runs.
// Sequencing:
//   a byte that needs no encryption is registered with its keystream byte,
//   then XORed into the m_axis output register; s_axis is held off while
//   a byte is pending between the two.
//   A block encryption runs key expansion, the rounds, a done pulse and the
//   keystream memory writes, one per byte. It runs on a start byte and after
//   every 16th byte, and s_axis is held off meanwhile.
// Reset: keystream zero (a clearing pass of the keystream memory, s_axis
// held off), position zero, key_size 256.
// A stalled m_axis holds its byte; s_axis is taken only when the output
// register is empty or being drained.
// ----------------------------------------------------------------------------
module aes_ofb_keystream_cipher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // data_byte[7:0], init_vector[39:8]
    input  logic        s_axis_tuser,   // start_req
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // plain_byte[7:0]
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data
);

    localparam int PW = $clog2(aoks_pkg::BLOCK_BYTES);

    // keystream memory, one byte per entry, registered read
    logic [7:0] ks_mem [0:aoks_pkg::BLOCK_BYTES-1];
    logic [7:0] ks_rd;

    logic [1:0]    key_size_reg;
    logic [PW-1:0] pos_reg, pos_next;
    logic          wait_reg, wait_next;
    logic          pend_reg, pend_next;
    logic [7:0]    data_reg;
    logic          last_reg;
    logic          ovalid_reg, ovalid_next;
    logic [7:0]    obyte_reg;
    logic          olast_reg;
    logic          wr_reg;
    logic [PW-1:0] wr_idx_reg;
    logic [127:0]  ks_full_reg;
    logic          take;
    logic          start;
    aoks_pkg::eng_req_t  req;
    aoks_pkg::eng_stat_t stat;
    logic [127:0]  enc_out;
    logic [127:0]  iv;

    aoks_engine u_engine
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .key_size (key_size_reg),
        .req      (req),
        .stat     (stat),
        .result   (enc_out)
    );

    assign start = s_axis_tuser;
    assign iv    = {4{s_axis_tdata[39:8]}};
    assign s_axis_tready = !wait_reg && !pend_reg && !stat.busy && !wr_reg &&
                           (!ovalid_reg || m_axis_tready);
    assign take = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = !stat.busy;

    // engine request: on start, or when the block ends
    always_comb
    begin
        req.go  = 1'b0;
        req.src = ks_full_reg;
        if (take && start)
        begin
            req.go  = 1'b1;
            req.src = iv;
        end
        else if (take && pos_reg == PW'(aoks_pkg::BLOCK_BYTES - 1))
            req.go = 1'b1;
    end

    // sequencing of bytes around the keystream reads
    always_comb
    begin
        pos_next    = pos_reg;
        wait_next   = wait_reg;
        pend_next   = 1'b0;
        ovalid_next = ovalid_reg;
        if (m_axis_tvalid && m_axis_tready)
            ovalid_next = 1'b0;
        if (take)
        begin
            if (start)
            begin
                pos_next  = PW'(1);
                wait_next = 1'b1;
            end
            else
            begin
                pos_next  = pos_reg + PW'(1);
                pend_next = 1'b1;
            end
        end
        // a start byte waits until the new keystream is in memory
        if (wr_reg && wr_idx_reg == PW'(aoks_pkg::BLOCK_BYTES - 1))
            wait_next = 1'b0;
        if (wr_reg && wait_reg)
            pend_next = 1'b0;
        if (pend_reg)
            ovalid_next = 1'b1;
    end

    // keystream memory write, single read per byte
    always_ff @(posedge clk)
    begin
        if (wr_reg)
            ks_mem[wr_idx_reg] <= ks_full_reg[wr_idx_reg*8 +: 8];
        ks_rd <= ks_mem[take ? (start ? PW'(0) : pos_reg) : PW'(0)];
        if (take)
        begin
            data_reg <= s_axis_tdata[7:0];
            last_reg <= s_axis_tlast;
        end
        if (pend_reg)
        begin
            obyte_reg <= data_reg ^ ks_rd;
            olast_reg <= last_reg;
        end
    end

    // control; the keystream memory is copied from the zero block after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_size_reg <= aoks_pkg::KEY_256;
            pos_reg      <= '0;
            wait_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            ovalid_reg   <= 1'b0;
            wr_reg       <= 1'b1;
            wr_idx_reg   <= '0;
            ks_full_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                key_size_reg <= cfg_data;
            pos_reg    <= pos_next;
            wait_reg   <= wait_next;
            pend_reg   <= pend_next || (wr_reg && wait_reg &&
                          wr_idx_reg == PW'(aoks_pkg::BLOCK_BYTES - 1));
            ovalid_reg <= ovalid_next;
            if (stat.done)
            begin
                ks_full_reg <= enc_out;
                wr_reg      <= 1'b1;
                wr_idx_reg  <= '0;
            end
            else if (wr_reg)
            begin
                wr_idx_reg <= wr_idx_reg + PW'(1);
                if (wr_idx_reg == PW'(aoks_pkg::BLOCK_BYTES - 1))
                    wr_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = obyte_reg;
    assign m_axis_tlast  = olast_reg;

    // no byte is taken while the keystream is being refilled
    a_no_take_wr: assert property (@(posedge clk) disable iff (!rst_n)
        wr_reg |-> !take) else $error("take during refill");
    // a pending byte always reaches the output register
    a_pend: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |=> ovalid_reg) else $error("pending byte lost");
    // a start always launches the engine
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (take && start) |=> stat.busy) else $error("start without engine");

endmodule

### hdl/aoks_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aoks_engine
// Iterative AES encryption core: key schedule expanded one word a cycle into
// a round key memory, then the rounds over the state, each applied once its round key is fetched.
// ----------------------------------------------------------------------------
module aoks_engine
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         key_size,
    input  aoks_pkg::eng_req_t req,
    output aoks_pkg::eng_stat_t stat,
    output logic [127:0]       result
);

    // round key word memory, 60 words
    logic [31:0] kmem [0:59];
    logic [31:0] kmem_rd_a;
    logic [31:0] kmem_rd_b;

    aoks_pkg::eng_state_t state_reg, state_next;
    logic [5:0]   widx_reg, widx_next;
    logic [3:0]   rnd_reg, rnd_next;
    logic [1:0]   sub_reg, sub_next;
    logic [127:0] st_reg, st_next;
    logic [127:0] src_reg;
    logic [127:0] rk_reg;
    logic         done_reg, done_next;
    logic [1:0]   sel;
    logic [3:0]   nk;
    logic [3:0]   nr;
    logic [5:0]   nwords;
    logic [31:0]  prev_reg;
    logic [31:0]  hist [0:7];
    logic [31:0]  t_word;
    logic [31:0]  new_word;
    logic [31:0]  key_word;
    logic [3:0]   imod;
    logic [3:0]   idiv;
    logic         kwe;
    logic [5:0]   kaddr;
    logic [5:0]   raddr;

    // effective key size, unused code runs as 256
    assign sel    = (key_size == 2'd3) ? aoks_pkg::KEY_256 : key_size;
    assign nk     = 4'd4 + {1'b0, sel, 1'b0};
    assign nr     = 4'd10 + {1'b0, sel, 1'b0};
    assign nwords = {nr, 2'b00} + 6'd4;

    // i mod nk and i / nk by small compare-subtract (i < 60)
    always_comb
    begin
        imod = 4'd0;
        idiv = 4'd0;
        for (int q = 0; q <= 15; q++)
            if ({2'b00, widx_reg} >= 8'(q) * {4'b0, nk} &&
                {2'b00, widx_reg} <  8'(q + 1) * {4'b0, nk})
            begin
                idiv = 4'(q);
                imod = 4'(8'({2'b00, widx_reg}) - 8'(q) * {4'b0, nk});
            end
    end

    // key word generation; hist holds the last nk words
    always_comb
    begin
        t_word = prev_reg;
        if (imod == 4'd0)
            t_word = {aoks_pkg::sbox(prev_reg[7:0]), aoks_pkg::sbox(prev_reg[31:24]),
                      aoks_pkg::sbox(prev_reg[23:16]),
                      aoks_pkg::sbox(prev_reg[15:8]) ^ aoks_pkg::rcon(idiv)};
        else if (nk == 4'd8 && imod == 4'd4)
            t_word = {aoks_pkg::sbox(prev_reg[31:24]), aoks_pkg::sbox(prev_reg[23:16]),
                      aoks_pkg::sbox(prev_reg[15:8]), aoks_pkg::sbox(prev_reg[7:0])};
        new_word = hist[3'(nk - 4'd1)] ^ t_word;
    end

    // first nk words come straight from the built-in key
    assign key_word = (widx_reg < 6'(nk)) ? aoks_pkg::FIXED_KEY[widx_reg[2:0]*32 +: 32]
                                          : new_word;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            aoks_pkg::ENG_IDLE:  if (req.go) state_next = aoks_pkg::ENG_KEYX;
            aoks_pkg::ENG_KEYX:  if (widx_reg == nwords - 6'd1) state_next = aoks_pkg::ENG_ROUND;
            aoks_pkg::ENG_ROUND:
                if (rnd_reg == nr && sub_reg == 2'd3) state_next = aoks_pkg::ENG_IDLE;
            default: state_next = aoks_pkg::ENG_IDLE;
        endcase
    end

    // datapath control
    always_comb
    begin
        widx_next = widx_reg;
        rnd_next  = rnd_reg;
        sub_next  = sub_reg;
        st_next   = st_reg;
        done_next = 1'b0;
        kwe       = 1'b0;
        kaddr     = widx_reg;
        raddr     = {rnd_reg, sub_reg};
        unique case (state_reg)
            aoks_pkg::ENG_IDLE:
            begin
                widx_next = 6'd0;
                rnd_next  = 4'd0;
                sub_next  = 2'd0;
            end
            aoks_pkg::ENG_KEYX:
            begin
                kwe       = 1'b1;
                widx_next = widx_reg + 6'd1;
                raddr     = 6'd0;
            end
            aoks_pkg::ENG_ROUND:
            begin
                // four reads fetch a round key; the last applies the round
                sub_next = sub_reg + 2'd1;
                raddr    = {rnd_reg, sub_reg + 2'd1};
                if (sub_reg == 2'd3)
                begin
                    raddr    = (rnd_reg == nr) ? 6'd0 : {rnd_reg + 4'd1, 2'd0};
                    rnd_next = rnd_reg + 4'd1;
                    if (rnd_reg == 4'd0)
                        st_next = src_reg ^ {kmem_rd_a, rk_reg[95:0]};
                    else if (rnd_reg == nr)
                    begin
                        st_next   = aoks_pkg::sub_shift(st_reg) ^ {kmem_rd_a, rk_reg[95:0]};
                        done_next = 1'b1;
                    end
                    else
                        st_next = aoks_pkg::mix_all(aoks_pkg::sub_shift(st_reg)) ^
                                  {kmem_rd_a, rk_reg[95:0]};
                end
            end
            default: ;
        endcase
    end

    // key memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (kwe)
            kmem[kaddr] <= key_word;
        kmem_rd_b <= kmem[raddr];
    end
    assign kmem_rd_a = kmem_rd_b;

    // key history shift and round key gather
    always_ff @(posedge clk)
    begin
        if (state_reg == aoks_pkg::ENG_IDLE && req.go)
            src_reg <= req.src;
        if (state_reg == aoks_pkg::ENG_ROUND && sub_reg != 2'd3)
            rk_reg[sub_reg*32 +: 32] <= kmem_rd_a;
        if (state_reg == aoks_pkg::ENG_KEYX)
        begin
            prev_reg <= key_word;
            for (int k = 7; k > 0; k--)
                hist[k] <= hist[k-1];
            hist[0] <= key_word;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aoks_pkg::ENG_IDLE;
            widx_reg  <= 6'd0;
            rnd_reg   <= 4'd0;
            sub_reg   <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            widx_reg  <= widx_next;
            rnd_reg   <= rnd_next;
            sub_reg   <= sub_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
        st_reg <= st_next;

    assign stat.busy = (state_reg != aoks_pkg::ENG_IDLE) || done_reg;
    assign stat.done = done_reg;
    assign result    = st_reg;

    // the done pulse lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("done held");
    // a request is only taken when idle
    a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req.go && state_reg != aoks_pkg::ENG_IDLE) |-> 1'b0) else $error("go while busy");
    // expansion never runs past the schedule
    a_widx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == aoks_pkg::ENG_KEYX |-> widx_reg < 6'd60) else $error("widx range");

endmodule

### sim/aoks_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aoks_checker
// Watches the stream and config channels of the OFB keystream cipher, keeps
// its own AES/OFB state, predicts every output byte and compares transfers.
// ----------------------------------------------------------------------------
module aoks_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // data_byte[7:0], init_vector[39:8]
    input  logic        s_axis_tuser,   // start_req
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,   // plain_byte[7:0]
    input  logic        m_axis_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    output int          fail_count,
    output int          bytes_pending
);

    typedef struct packed {
        logic [7:0] plain;
        logic       lst;
    } plain_byte_t;

    plain_byte_t  plain_q[$];
    logic [1:0]   key_sel;
    logic [127:0] keystream;
    logic [3:0]   pos;

    // gf(2^8) multiply
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    // s-box from inverse (a^254) plus affine map
    function automatic logic [7:0] subst_byte(input logic [7:0] a);
        logic [7:0] inv, sq, s;
        inv = 8'h01;
        sq  = a;
        for (int i = 0; i < 8; i++)
        begin
            if (i != 0)
                inv = gf_mul(inv, sq);
            sq = gf_mul(sq, sq);
        end
        s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
            ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        return s;
    endfunction

    // full block encryption under the built-in key
    function automatic logic [127:0] aes_block(input logic [127:0] src,
                                               input logic [1:0] ksz);
        logic [7:0] w[240];
        logic [7:0] st[16];
        logic [7:0] old[16];
        logic [7:0] t[4];
        logic [7:0] tmp, rc, a0, a1, a2, a3, al;
        logic [127:0] res;
        int sel, nk, nr;
        sel = (ksz == 2'd3) ? 2 : int'(ksz);
        nk  = 4 + 2 * sel;
        nr  = 10 + 2 * sel;
        for (int i = 0; i < 4 * nk; i++)
            w[i] = aoks_pkg::FIXED_KEY[8*i +: 8];
        rc = 8'h01;
        for (int i = nk; i < 4 * (nr + 1); i++)
        begin
            for (int b = 0; b < 4; b++)
                t[b] = w[4*(i-1)+b];
            if (i % nk == 0)
            begin
                tmp  = t[0];
                t[0] = subst_byte(t[1]) ^ rc;
                t[1] = subst_byte(t[2]);
                t[2] = subst_byte(t[3]);
                t[3] = subst_byte(tmp);
                rc   = gf_mul(rc, 8'h02);
            end
            else if (nk == 8 && i % nk == 4)
            begin
                for (int b = 0; b < 4; b++)
                    t[b] = subst_byte(t[b]);
            end
            for (int b = 0; b < 4; b++)
                w[4*i+b] = w[4*(i-nk)+b] ^ t[b];
        end
        for (int i = 0; i < 16; i++)
            st[i] = src[8*i +: 8] ^ w[i];
        for (int r = 1; r <= nr; r++)
        begin
            old = st;
            for (int c = 0; c < 4; c++)
                for (int q = 0; q < 4; q++)
                    st[c*4+q] = subst_byte(old[((c + q) & 3)*4 + q]);
            if (r != nr)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = st[c*4]; a1 = st[c*4+1]; a2 = st[c*4+2]; a3 = st[c*4+3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    st[c*4]   = a0 ^ al ^ gf_mul(a0 ^ a1, 8'h02);
                    st[c*4+1] = a1 ^ al ^ gf_mul(a1 ^ a2, 8'h02);
                    st[c*4+2] = a2 ^ al ^ gf_mul(a2 ^ a3, 8'h02);
                    st[c*4+3] = a3 ^ al ^ gf_mul(a3 ^ a0, 8'h02);
                end
            end
            for (int i = 0; i < 16; i++)
                st[i] ^= w[16*r+i];
        end
        for (int i = 0; i < 16; i++)
            res[8*i +: 8] = st[i];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("[%0t] mismatch %s: got %02h, expected %02h", $time, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count    = 0;
        bytes_pending = 0;
    end

    // predict on input transfers, compare on output transfers
    always @(posedge clk or negedge rst_n)
    begin
        plain_byte_t exp_b;
        logic [127:0] iv;
        if (!rst_n)
        begin
            plain_q.delete();
            key_sel   = aoks_pkg::KEY_256;
            keystream = '0;
            pos       = '0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (plain_q.size() == 0)
                begin
                    $display("[%0t] unexpected output byte %02h", $time, m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    exp_b = plain_q.pop_front();
                    if (m_axis_tdata !== exp_b.plain)
                        report_mismatch("plain byte", m_axis_tdata, exp_b.plain);
                    if (m_axis_tlast !== exp_b.lst)
                        report_mismatch("tlast", {7'd0, m_axis_tlast}, {7'd0, exp_b.lst});
                end
            end
            if (cfg_valid && cfg_ready)
                key_sel = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser)
                begin
                    for (int i = 0; i < 16; i++)
                        iv[8*i +: 8] = s_axis_tdata[8 + 8*(i & 3) +: 8];
                    keystream = aes_block(iv, key_sel);
                    pos = '0;
                end
                exp_b.plain = s_axis_tdata[7:0] ^ keystream[8*pos +: 8];
                exp_b.lst   = s_axis_tlast;
                plain_q.push_back(exp_b);
                pos = pos + 4'd1;
                if (pos == 4'd0)
                    keystream = aes_block(keystream, key_sel);
            end
        end
        bytes_pending = plain_q.size();
    end

endmodule

### sim/tb_aes_ofb_keystream_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aes_ofb_keystream_cipher
// Drives byte packets with random gaps and back-pressure through the cipher
// under every key size; the checker predicts and compares each output byte.
// ----------------------------------------------------------------------------
module tb_aes_ofb_keystream_cipher;

    localparam int DRAIN_CYCLES = 300;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // data_byte[7:0], init_vector[39:8]
    logic        s_axis_tuser;   // start_req
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // plain_byte[7:0]
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_data;
    int          fail_count;
    int          bytes_pending;
    int          rx_hold;
    int          rx_quiet;

    aes_ofb_keystream_cipher uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    aoks_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .bytes_pending(bytes_pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // gap length: mostly none or short, rarely long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 4);
        else
            return $urandom_range(10, 40);
    endfunction

    // receiver back-pressure, with quiet stretches of no stalls
    always @(negedge clk)
    begin
        if (rx_quiet > 0)
        begin
            rx_quiet--;
            m_axis_tready <= 1'b1;
        end
        else if (rx_hold > 0)
        begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 199) == 0)
                rx_quiet = $urandom_range(50, 200);
            else
                rx_hold = pick_gap();
        end
    end

    task automatic send_byte(input logic [7:0] data, input logic [31:0] vec,
                             input logic start, input logic lst);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {vec, data};
        s_axis_tuser  = start;
        s_axis_tlast  = lst;
        forever
        begin
            @(posedge clk);
            if (s_axis_tready)
                break;
        end
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (bytes_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_key_size(input logic [1:0] ksz);
        drain();
        cfg_valid = 1'b1;
        cfg_data  = ksz;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // random packets: mostly well-formed, some noise bytes without start
    task automatic random_traffic(input int n_bytes);
        int sent, len;
        logic [31:0] vec;
        sent = 0;
        while (sent < n_bytes)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 70)
                                              : $urandom_range(1, 34);
            vec = $urandom();
            for (int i = 0; i < len; i++)
            begin
                send_byte(8'($urandom_range(0, 255)), $urandom(),
                          (i == 0) && ($urandom_range(0, 9) != 0),
                          (i == len - 1) ? 1'b1 : ($urandom_range(0, 30) == 0));
                sent++;
            end
            if (vec[4:0] == 5'd0)
                drain();
        end
    endtask

    // stimulus
    initial
    begin
        logic [1:0] key_order[4];
        key_order = '{aoks_pkg::KEY_128, aoks_pkg::KEY_192, 2'd3, aoks_pkg::KEY_256};
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = aoks_pkg::KEY_256;
        m_axis_tready = 1'b0;
        rx_hold       = 0;
        rx_quiet      = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // bytes before any start: zero keystream, then its encryption
        for (int i = 0; i < 18; i++)
            send_byte((i % 2) ? 8'hff : 8'h00, 32'hffffffff, 1'b0, i == 17);
        // extreme vectors, start mid-packet, bytes after last
        send_byte(8'h00, 32'h00000000, 1'b1, 1'b0);
        send_byte(8'hff, 32'h00000000, 1'b0, 1'b0);
        send_byte(8'h5a, 32'hffffffff, 1'b1, 1'b1);
        send_byte(8'ha5, 32'h12345678, 1'b0, 1'b0);
        send_byte(8'h3c, 32'h80000001, 1'b1, 1'b1);
        send_byte(8'hc3, 32'h00000000, 1'b0, 1'b1);

        random_traffic(240);
        for (int k = 0; k < 4; k++)
        begin
            write_key_size(key_order[k]);
            send_byte(8'($urandom_range(0, 255)), $urandom(), 1'b1, 1'b0);
            random_traffic(240);
        end
        drain();

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
